[sv/lpfd_pkg.sv]
package lpfd_pkg;

  localparam int HEADER_BYTES = 4;
  localparam int HDR_CNT_W    = 2;
  localparam int PADDR_W      = 3;

  localparam logic [31:0] MAX_FRAME_RESET = 32'd65536;

  localparam logic REG_MAX_FRAME = 1'b0;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_HALT   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_LARGE = 2'd2,
    ST_UTF8  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    status_t    status;
  } result_t;

endpackage

[sv/lpfd_if.sv]
interface lpfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lpfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic [1:0] status;

  modport source (output valid, output out_byte, output frame_end, output status, input ready);
  modport sink (input valid, input out_byte, input frame_end, input status, output ready);
endinterface

[sv/lpfd_regs.sv]
module lpfd_regs
  import lpfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [31:0]        frame_cap
);

  logic wr;
  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr[2] == REG_MAX_FRAME);
  assign wr     = psel && penable && pwrite && pready;
  assign prdata = hit ? frame_cap : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cap <= MAX_FRAME_RESET;
    end else if (wr && hit) begin
      frame_cap <= pwdata;
    end
  end

endmodule

[sv/lpfd_core.sv]
module lpfd_core
  import lpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic [31:0] frame_cap,
  output logic        res_valid,
  output result_t     result
);

  phase_t               phase;
  phase_t               phase_next;
  logic [HDR_CNT_W-1:0] header_count;
  logic [31:0]          length_acc;
  logic [31:0]          body_left;
  logic [1:0]           cont_left;
  logic                 utf8_bad;

  logic [31:0] length_full;
  logic        hdr_last;
  logic        len_zero;
  logic        len_large;
  logic        body_last;
  logic [1:0]  cont_chk;
  logic        bad_chk;
  logic        bad_end;

  assign length_full = {length_acc[23:0], in_byte};
  assign hdr_last    = (header_count == HDR_CNT_W'(HEADER_BYTES - 1));
  assign len_zero    = (length_full == 32'd0);
  assign len_large   = (length_full > frame_cap);
  assign body_last   = (body_left == 32'd1);
  assign bad_end     = bad_chk || (cont_chk != 2'd0);

  always_comb begin
    cont_chk = cont_left;
    bad_chk  = utf8_bad;
    if (cont_left != 2'd0) begin
      if ((in_byte & CONT_MASK) != CONT_TAG) bad_chk = 1'b1;
      cont_chk = cont_left - 2'd1;
    end else begin
      priority if (!in_byte[7]) begin
        cont_chk = 2'd0;
      end else if ((in_byte & LEAD2_MASK) == LEAD2_TAG) begin
        cont_chk = 2'd1;
      end else if ((in_byte & LEAD3_MASK) == LEAD3_TAG) begin
        cont_chk = 2'd2;
      end else if ((in_byte & LEAD4_MASK) == LEAD4_TAG) begin
        cont_chk = 2'd3;
      end else begin
        bad_chk = 1'b1;
      end
    end
  end

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          if (hdr_last) phase_next = (len_zero || len_large) ? PH_HALT : PH_BODY;
        end
        PH_BODY: begin
          if (body_last) phase_next = bad_end ? PH_HALT : PH_HEADER;
        end
        default: phase_next = phase;
      endcase
    end
  end

  always_comb begin
    res_valid        = 1'b0;
    result.out_byte  = in_byte;
    result.frame_end = 1'b0;
    result.status    = ST_OK;
    unique case (phase)
      PH_HEADER: begin
        res_valid        = accept && hdr_last && (len_zero || len_large);
        result.out_byte  = 8'd0;
        result.frame_end = 1'b1;
        result.status    = len_zero ? ST_ZERO : ST_LARGE;
      end
      PH_BODY: begin
        res_valid        = accept;
        result.frame_end = body_last;
        result.status    = (body_last && bad_end) ? ST_UTF8 : ST_OK;
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= '0;
      length_acc   <= '0;
      body_left    <= '0;
      cont_left    <= '0;
      utf8_bad     <= 1'b0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        unique case (phase)
          PH_HEADER: begin
            length_acc <= length_full;
            if (!hdr_last) begin
              header_count <= header_count + HDR_CNT_W'(1);
            end else begin
              header_count <= '0;
              if (!len_zero && !len_large) begin
                body_left  <= length_full;
                length_acc <= '0;
                cont_left  <= '0;
                utf8_bad   <= 1'b0;
              end
            end
          end
          PH_BODY: begin
            body_left <= body_left - 32'd1;
            if (body_last && !bad_end) begin
              cont_left <= '0;
              utf8_bad  <= 1'b0;
            end else begin
              cont_left <= cont_chk;
              utf8_bad  <= bad_chk;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

[sv/lpfd_out_skid.sv]
module lpfd_out_skid
  import lpfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_data,
  output logic    in_ready,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_ready
);

  logic    skid_valid;
  result_t skid_data;
  logic    hold;

  assign in_ready = !skid_valid;
  assign hold     = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (hold) begin
      if (in_valid) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hold) begin
      if (in_valid) skid_data <= in_data;
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (in_valid) begin
      out_data <= in_data;
    end
  end

endmodule

[sv/length_prefixed_frame_decoder_top.sv]
// Length-prefixed frame decoder.
// rx carries the raw byte stream; tx carries one result per body byte and
// one result for a bad header. Each frame is a 4-byte big-endian length and
// then that many body bytes. Header bytes give no result except the last one
// when the length is zero or above the frame length limit (status 1 or 2).
// The last body byte has frame_end set and status 3 if the body was not
// valid UTF-8. Any error halts the decoder: later bytes are taken and
// dropped until reset. Bodies stream through, so discard a frame that ends
// in an error.
// Throughput: one byte per cycle while rx.ready is high. Each result is
// registered in the output buffer when its byte transfers on rx; the length
// and UTF-8 counters update on that same transfer.
// A two-entry output buffer (output register plus skid register) absorbs one
// more result while tx stalls; rx.ready then drops until tx takes a result
// and rises again in the cycle after that transfer.
// Reset (rst, synchronous) clears the decoder to the header phase, empties
// the output buffer and sets the frame length limit (word 0 on the APB port)
// to 65536. Write the register only while the decoder is idle.
module length_prefixed_frame_decoder_top
  import lpfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  lpfd_in_if.sink            rx,
  lpfd_out_if.source         tx
);

  logic [31:0] frame_cap;
  logic        accept;
  logic        res_valid;
  result_t     result;
  result_t     tx_data;

  lpfd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .frame_cap (frame_cap)
  );

  assign accept = rx.valid && rx.ready;

  lpfd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (rx.in_byte),
    .frame_cap (frame_cap),
    .res_valid (res_valid),
    .result    (result)
  );

  lpfd_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (result),
    .in_ready  (rx.ready),
    .out_valid (tx.valid),
    .out_data  (tx_data),
    .out_ready (tx.ready)
  );

  assign tx.out_byte  = tx_data.out_byte;
  assign tx.frame_end = tx_data.frame_end;
  assign tx.status    = tx_data.status;

endmodule

[sv/lpfd_checker.sv]
module lpfd_checker
  import lpfd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] tx_out_byte,
  input logic       tx_frame_end,
  input logic [1:0] tx_status
);

  a_tx_hold_valid: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid)
    else $error("tx valid dropped while stalled");

  a_tx_hold_data: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> $stable(tx_out_byte) && $stable(tx_frame_end)
      && $stable(tx_status))
    else $error("tx payload changed while stalled");

  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_ready && (tx_status != ST_OK) |=> !tx_valid)
    else $error("result after an error transfer");

  a_err_ends_frame: assert property (@(posedge clk) disable iff (rst)
    tx_valid && (tx_status != ST_OK) |-> tx_frame_end)
    else $error("error status without frame_end");

  a_hdr_err_zero: assert property (@(posedge clk) disable iff (rst)
    tx_valid && (tx_status == ST_ZERO || tx_status == ST_LARGE) |-> tx_out_byte == 8'd0)
    else $error("header error carries a nonzero byte");

endmodule

bind length_prefixed_frame_decoder_top lpfd_checker u_lpfd_checker (
  .clk          (clk),
  .rst          (rst),
  .tx_valid     (tx.valid),
  .tx_ready     (tx.ready),
  .tx_out_byte  (tx.out_byte),
  .tx_frame_end (tx.frame_end),
  .tx_status    (tx.status)
);

[tb/tb_length_prefixed_frame_decoder_top.sv]
module tb_length_prefixed_frame_decoder_top;
  import lpfd_pkg::*;

  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TRAILING_BYTES = 40;
  localparam logic [PADDR_W-1:0] MAX_FRAME_ADDR = {REG_MAX_FRAME, 2'b00};

  typedef enum {
    BAD_ZERO_LENGTH,
    BAD_TOO_LARGE,
    BAD_LEAD_BYTE,
    BAD_CONTINUATION,
    BAD_CUT_SEQUENCE
  } bad_frame_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  lpfd_in_if  rx_if ();
  lpfd_out_if tx_if ();

  length_prefixed_frame_decoder_top DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx      (rx_if),
    .tx      (tx_if)
  );

  logic [7:0]  pending_bytes[$];
  result_t     decoded_expect[$];
  result_t     want;

  phase_t      dec_phase;
  logic [1:0]  hdr_cnt;
  logic [1:0]  cont_owed;
  logic [31:0] len_acc;
  logic [31:0] body_left;
  logic        utf8_bad;
  logic [31:0] frame_limit = MAX_FRAME_RESET;

  logic        rx_xfer = 1'b0;
  int          quiet_cycles = 0;
  int          err_count = 0;
  int          bytes_in = 0;
  int          bytes_queued = 0;
  int          results_seen = 0;
  int          frames_ok = 0;
  int          hold_left;
  bit          no_gaps;
  bit          hold_req;
  bad_frame_t  last_bad;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic emit_result(input logic [7:0] b, input logic fe, input status_t st);
    result_t r;
    r.out_byte  = b;
    r.frame_end = fe;
    r.status    = st;
    decoded_expect = {decoded_expect, r};
  endtask

  task automatic decode_byte(input logic [7:0] b);
    if (dec_phase == PH_HEADER) begin
      len_acc = {len_acc[23:0], b};
      if (hdr_cnt != 2'(HEADER_BYTES - 1)) begin
        hdr_cnt = hdr_cnt + 2'd1;
      end else begin
        hdr_cnt = '0;
        if (len_acc == '0) begin
          dec_phase = PH_HALT;
          emit_result(8'h00, 1'b1, ST_ZERO);
        end else if (len_acc > frame_limit) begin
          dec_phase = PH_HALT;
          emit_result(8'h00, 1'b1, ST_LARGE);
        end else begin
          body_left = len_acc;
          len_acc   = '0;
          cont_owed = '0;
          utf8_bad  = 1'b0;
          dec_phase = PH_BODY;
        end
      end
    end else if (dec_phase == PH_BODY) begin
      if (cont_owed != '0) begin
        if ((b & CONT_MASK) != CONT_TAG) utf8_bad = 1'b1;
        cont_owed = cont_owed - 2'd1;
      end else if (b[7]) begin
        if ((b & LEAD2_MASK) == LEAD2_TAG) cont_owed = 2'd1;
        else if ((b & LEAD3_MASK) == LEAD3_TAG) cont_owed = 2'd2;
        else if ((b & LEAD4_MASK) == LEAD4_TAG) cont_owed = 2'd3;
        else utf8_bad = 1'b1;
      end
      body_left = body_left - 32'd1;
      if (body_left != '0) begin
        emit_result(b, 1'b0, ST_OK);
      end else if (utf8_bad || cont_owed != '0) begin
        dec_phase = PH_HALT;
        emit_result(b, 1'b1, ST_UTF8);
      end else begin
        dec_phase = PH_HEADER;
        cont_owed = '0;
        utf8_bad  = 1'b0;
        emit_result(b, 1'b1, ST_OK);
      end
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes = {pending_bytes, b};
    bytes_queued++;
  endtask

  task automatic queue_header(input logic [31:0] len);
    queue_byte(len[31:24]);
    queue_byte(len[23:16]);
    queue_byte(len[15:8]);
    queue_byte(len[7:0]);
  endtask

  // fill exactly n bytes with well-formed characters of random width
  task automatic queue_chars(input int unsigned n);
    int unsigned left;
    int unsigned w;
    left = n;
    while (left != 0) begin
      w = $urandom_range((left < 4) ? left : 4, 1);
      case (w)
        1: queue_byte(8'($urandom_range(127, 0)));
        2: queue_byte(LEAD2_TAG | 8'($urandom_range(31, 0)));
        3: queue_byte(LEAD3_TAG | 8'($urandom_range(15, 0)));
        default: queue_byte(LEAD4_TAG | 8'($urandom_range(7, 0)));
      endcase
      repeat (w - 1) queue_byte(CONT_TAG | 8'($urandom_range(63, 0)));
      left -= w;
    end
  endtask

  task automatic queue_frame(input int unsigned len);
    queue_header(len);
    queue_chars(len);
  endtask

  task automatic queue_bad_frame(input bad_frame_t kind);
    int unsigned len;
    int unsigned pos;
    case (kind)
      BAD_ZERO_LENGTH: queue_header('0);
      BAD_TOO_LARGE: queue_header(($urandom_range(1, 0) != 0) ? frame_limit + 32'd1
                                                               : 32'hFFFF_FFFF);
      BAD_LEAD_BYTE: begin
        len = $urandom_range(frame_limit, 1);
        pos = $urandom_range(len - 1, 0);
        queue_header(len);
        queue_chars(pos);
        if ($urandom_range(1, 0) != 0) queue_byte(CONT_TAG | 8'($urandom_range(63, 0)));
        else queue_byte(LEAD4_MASK | 8'($urandom_range(7, 0)));
        queue_chars(len - pos - 1);
      end
      BAD_CONTINUATION: begin
        len = $urandom_range(frame_limit, 2);
        pos = $urandom_range(len - 2, 0);
        queue_header(len);
        queue_chars(pos);
        queue_byte(LEAD2_TAG | 8'($urandom_range(31, 0)));
        if ($urandom_range(1, 0) != 0) queue_byte(8'($urandom_range(127, 0)));
        else queue_byte(CONT_MASK | 8'($urandom_range(63, 0)));
        queue_chars(len - pos - 2);
      end
      default: begin
        len = $urandom_range(frame_limit, 1);
        queue_header(len);
        queue_chars(len - 1);
        case ($urandom_range(2, 0))
          0: queue_byte(LEAD2_TAG | 8'($urandom_range(31, 0)));
          1: queue_byte(LEAD3_TAG | 8'($urandom_range(15, 0)));
          default: queue_byte(LEAD4_TAG | 8'($urandom_range(7, 0)));
        endcase
      end
    endcase
  endtask

  task automatic write_max_frame(input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_FRAME_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    frame_limit = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_max_frame();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MAX_FRAME_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== frame_limit) begin
      $error("frame_cap: expected %0d, got %0d", frame_limit, prdata);
      err_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || decoded_expect.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // sender: hold an offered byte until it transfers
  always @(negedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || rx_xfer) begin
      if (pending_bytes.size() != 0 && (no_gaps || $urandom_range(99, 0) >= 29)) begin
        rx_if.valid   <= 1'b1;
        rx_if.in_byte <= pending_bytes[0];
      end else begin
        rx_if.valid   <= 1'b0;
        rx_if.in_byte <= 8'($urandom);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      tx_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      tx_if.ready <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_req) begin
      tx_if.ready <= 1'b0;
      hold_left   <= LONG_HOLD;
      hold_req    <= 1'b0;
    end else begin
      tx_if.ready <= no_gaps || $urandom_range(99, 0) >= 29;
    end
  end

  always @(posedge clk) begin
    rx_xfer <= !rst && rx_if.valid && rx_if.ready;
    if (rst) begin
      dec_phase = PH_HEADER;
      hdr_cnt   = '0;
      cont_owed = '0;
      len_acc   = '0;
      body_left = '0;
      utf8_bad  = 1'b0;
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready)) ?
                      0 : quiet_cycles + 1;
      if (rx_if.valid && rx_if.ready) begin
        void'(pending_bytes.pop_front());
        bytes_in++;
        decode_byte(rx_if.in_byte);
      end
      if (tx_if.valid && tx_if.ready) begin
        results_seen++;
        if (decoded_expect.size() == 0) begin
          $error("unexpected result: out_byte %0d frame_end %0d status %0d",
                 tx_if.out_byte, tx_if.frame_end, tx_if.status);
          err_count++;
        end else begin
          want = decoded_expect.pop_front();
          if (tx_if.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0d, got %0d", want.out_byte, tx_if.out_byte);
            err_count++;
          end
          if (tx_if.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, tx_if.frame_end);
            err_count++;
          end
          if (tx_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, tx_if.status);
            err_count++;
          end
          if (want.frame_end && want.status == ST_OK) frames_ok++;
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int goal;
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rx_if.valid   = 1'b0;
    rx_if.in_byte = '0;
    tx_if.ready   = 1'b0;
    no_gaps       = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_max_frame();
    queue_header(32'd1);
    queue_byte(8'h00);
    queue_header(32'd4);
    queue_byte(8'hF7);
    queue_byte(8'hBF);
    queue_byte(8'hBF);
    queue_byte(8'hBF);
    queue_header(32'd6);
    queue_byte(8'hE0);
    queue_byte(8'h80);
    queue_byte(8'h80);
    queue_byte(8'hDF);
    queue_byte(8'hBF);
    queue_byte(8'h7F);
    wait_drained();

    write_max_frame(32'd1);
    check_max_frame();
    repeat (50) queue_frame(1);
    wait_drained();

    // long receiver hold while the sender keeps offering
    write_max_frame(32'hFFFF_FFFF);
    check_max_frame();
    queue_frame(300);
    goal = bytes_queued + 300;
    while (bytes_queued < goal) queue_frame($urandom_range(40, 1));
    @(posedge clk);
    hold_req = 1'b1;
    wait_drained();

    no_gaps = 1'b1;
    write_max_frame(32'($urandom_range(64, 8)));
    check_max_frame();
    queue_frame(frame_limit);
    goal = bytes_queued + 500;
    while (bytes_queued < goal) queue_frame($urandom_range(frame_limit, 1));
    wait_drained();
    no_gaps = 1'b0;

    write_max_frame(32'($urandom_range(32, 4)));
    check_max_frame();
    goal = bytes_queued + 300;
    while (bytes_queued < goal) queue_frame($urandom_range(frame_limit, 1));
    last_bad = bad_frame_t'($urandom_range(4, 0));
    queue_bad_frame(last_bad);
    repeat (TRAILING_BYTES) queue_byte(8'($urandom));
    wait_drained();
    repeat (8) @(negedge clk);

    $display("covered %0d input bytes, %0d results, %0d clean frames over five limits",
             bytes_in, results_seen, frames_ok);
    $display("final frame: %s, followed by %0d dropped bytes",
             last_bad.name(), TRAILING_BYTES);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
